### rtl/core/skvt_pkg.sv
// Shared types and codes for the sorted key/value table.
`default_nettype none

package skvt_pkg;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_LIST   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] entry_key;
    logic [31:0] entry_value;
    logic        last;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] value;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/skvt_mem.sv
// Entry storage: one write port, one registered read port.
`default_nettype none

module skvt_mem import skvt_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write the entry at the write address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data; hold it between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/sorted_key_value_table_top.sv
// Sorted key/value table: sequencer over an entry store with separate write and read ports.
//
// Input beats carry an operation, a key and a value on in_data; results
// leave on out_data, one beat per item except list, which sends one beat
// per stored entry with last set on the final one (a single not-found beat
// when the table is empty). Both channels use valid/ready.
// One item is processed at a time; in_ready is high only while the
// sequencer is idle. All entry reads go through the one store read port:
//   lookup/update: scan entries in order until the key is met or passed
//   insert:        scan for the slot, then read each later entry and
//                  write it back one slot higher, then write the new entry
//   list:          read, then send, each entry in turn
// A finished result sits in an output register, so the next item can be
// taken while the receiver stalls; a stalled receiver holds the sequencer
// only when it has another result to hand over.
// Reset empties the table (entry count zero); store contents are not
// cleared and are never read before being written.
`default_nettype none

module sorted_key_value_table_top import skvt_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_SHIFT    = 3'd2;
  localparam logic [2:0] S_RESP     = 3'd3;
  localparam logic [2:0] S_LIST_RD  = 3'd4;
  localparam logic [2:0] S_LIST_OUT = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  in_item_t      req_r, req_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] wr_idx_r, wr_idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  out_item_t     res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  logic          out_free;
  logic          stop;
  logic          done;
  logic          hit;
  logic [CW-1:0] cmp_idx;
  logic [CW-1:0] found;
  logic          list_last;

  skvt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequencer next state and store access
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    rem_nxt       = rem_r;
    wr_idx_nxt    = wr_idx_r;
    pos_nxt       = pos_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r[AW-1:0];
    wr_data       = '{key: req_r.key, value: req_r.value};
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    stop          = 1'b0;
    done          = 1'b0;
    hit           = 1'b0;
    found         = count_r;
    cmp_idx       = idx_r - ONE_C;
    list_last     = ((idx_r + ONE_C) == count_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          rem_nxt  = '0;
          pos_nxt  = '0;
          res_nxt  = '{status: ST_MISSING, entry_key: '0, entry_value: '0, last: 1'b1};
          if (in_data.operation == OP_INSERT) begin
            if (count_r >= CAP_C) begin
              res_nxt.status = ST_FULL;
              state_nxt      = S_RESP;
            end else if (count_r == '0) begin
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (count_r == '0) begin
            state_nxt = S_RESP;
          end else if (in_data.operation == OP_LIST) begin
            state_nxt = S_LIST_RD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Compare the entry read last cycle
        if (pend_r) begin
          if (cmp_idx == '0 && req_r.operation == OP_INSERT) begin
            stop = (rd_data.key > req_r.key);
          end else begin
            stop = (rd_data.key >= req_r.key);
          end
        end
        if (stop) begin
          done  = 1'b1;
          found = cmp_idx;
          hit   = (rd_data.key == req_r.key);
        end else if (idx_r != count_r) begin
          // Issue the next read
          rd_en    = 1'b1;
          idx_nxt  = idx_r + ONE_C;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          done     = !pend_r;
        end
        if (done) begin
          if (req_r.operation == OP_INSERT) begin
            pos_nxt   = found;
            rem_nxt   = count_r - found;
            idx_nxt   = count_r - ONE_C;
            pend_nxt  = 1'b0;
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_RESP;
            if (hit) begin
              res_nxt.status    = ST_OK;
              res_nxt.entry_key = rd_data.key;
              if (req_r.operation == OP_UPDATE) begin
                res_nxt.entry_value = req_r.value;
                wr_en               = 1'b1;
                wr_addr             = found[AW-1:0];
                wr_data             = '{key: rd_data.key, value: req_r.value};
              end else begin
                res_nxt.entry_value = rd_data.value;
              end
            end
          end
        end
      end

      S_SHIFT: begin
        // Write back the entry read last cycle one slot higher
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = wr_idx_r[AW-1:0];
          wr_data = rd_data;
        end
        if (rem_r != '0) begin
          rd_en      = 1'b1;
          wr_idx_nxt = idx_r + ONE_C;
          idx_nxt    = idx_r - ONE_C;
          rem_nxt    = rem_r - ONE_C;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            // Drop the new entry into its slot
            wr_en     = 1'b1;
            wr_addr   = pos_r[AW-1:0];
            count_nxt = count_r + ONE_C;
            res_nxt   = '{status: ST_OK, entry_key: '0, entry_value: '0, last: 1'b1};
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      S_LIST_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, entry_key: rd_data.key,
                            entry_value: rd_data.value, last: list_last};
          idx_nxt       = idx_r + ONE_C;
          state_nxt     = list_last ? S_IDLE : S_LIST_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    wr_idx_r   <= wr_idx_nxt;
    pos_r      <= pos_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

### tb/tb_sorted_key_value_table_top.sv
// Self-checking testbench for the sorted key/value table: random and directed operations.
`timescale 1ns / 1ps

module tb_sorted_key_value_table_top import skvt_pkg::*; ();

  localparam int CAPACITY   = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int RX_HOLD    = 300;
  localparam int TAIL_CYCLES = 150;

  // One entry of the stimulus list: an operation beat or a pause until drained
  typedef struct {
    in_item_t item;
    bit       drain;
  } queued_op_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  queued_op_t  op_queue[$];
  out_item_t   expected_replies[$];
  logic [15:0] gen_keys[$];

  // Shadow copy of the table contents
  logic [15:0] tbl_key[CAPACITY];
  logic [31:0] tbl_value[CAPACITY];
  int          tbl_count = 0;

  int ops_accepted = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  int hold_idx = 0;
  int hold_at[2] = '{60, 330};

  sorted_key_value_table_top #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Idle rate for both sides; a window of operations runs with no idling
  function automatic int idle_pct();
    return (ops_accepted >= 150 && ops_accepted < 240) ? 0 : 32;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Apply one operation to the shadow table and queue the replies it causes
  function automatic void apply_table_op(in_item_t op);
    out_item_t r;
    int        pos;
    int        i;
    r = '0;
    r.last = 1'b1;
    case (op.operation)
      OP_INSERT: begin
        if (tbl_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (tbl_count == 0 || op.key < tbl_key[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < tbl_count && tbl_key[pos] < op.key) pos++;
          end
          for (i = tbl_count; i > pos; i--) begin
            tbl_key[i]   = tbl_key[i-1];
            tbl_value[i] = tbl_value[i-1];
          end
          tbl_key[pos]   = op.key;
          tbl_value[pos] = op.value;
          tbl_count++;
          r.status = ST_OK;
        end
        expected_replies.push_back(r);
      end
      OP_LOOKUP, OP_UPDATE: begin
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] < op.key) pos++;
        if (pos < tbl_count && tbl_key[pos] == op.key) begin
          if (op.operation == OP_UPDATE) tbl_value[pos] = op.value;
          r.status      = ST_OK;
          r.entry_key   = tbl_key[pos];
          r.entry_value = tbl_value[pos];
        end else begin
          r.status = ST_MISSING;
        end
        expected_replies.push_back(r);
      end
      default: begin
        if (tbl_count == 0) begin
          r.status = ST_MISSING;
          expected_replies.push_back(r);
        end else begin
          for (i = 0; i < tbl_count; i++) begin
            r.status      = ST_OK;
            r.entry_key   = tbl_key[i];
            r.entry_value = tbl_value[i];
            r.last        = (i == tbl_count - 1);
            expected_replies.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // Sender: offer queued operations, predict on each accepted beat
  always @(posedge clk) begin
    queued_op_t head;
    logic       launch;
    launch = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_table_op(in_data);
        ops_accepted++;
      end
      // hold the current beat until it is taken
      if (!(in_valid && !in_ready)) begin
        if (op_queue.size() > 0) begin
          if (op_queue[0].drain) begin
            if (expected_replies.size() == 0 && !in_valid) void'(op_queue.pop_front());
          end else if ($urandom_range(99) >= idle_pct()) begin
            head = op_queue.pop_front();
            launch = 1'b1;
          end
        end
        in_valid <= launch;
        if (launch) in_data <= head.item;
      end
    end
  end

  // Receiver: check each reply beat, stall at random and in long holds
  always @(posedge clk) begin
    out_item_t want;
    logic      nxt_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with nothing expected", out_data.entry_key,
                          out_data.entry_value);
        end else begin
          want = expected_replies.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.entry_key !== want.entry_key)
            report_mismatch("entry_key", out_data.entry_key, want.entry_key);
          if (out_data.entry_value !== want.entry_value)
            report_mismatch("entry_value", out_data.entry_value, want.entry_value);
          if (out_data.last !== want.last)
            report_mismatch("last", out_data.last, want.last);
        end
      end
      if (hold_left == 0 && hold_idx < 2 && ops_accepted >= hold_at[hold_idx]) begin
        hold_left = RX_HOLD;
        hold_idx++;
      end
      if (hold_left > 0) begin
        nxt_ready = 1'b0;
        hold_left--;
      end else begin
        nxt_ready = ($urandom_range(99) >= idle_pct());
      end
      out_ready <= nxt_ready;
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic queue_op(logic [1:0] opc, logic [15:0] k, logic [31:0] v);
    queued_op_t q;
    q.item.operation = opc;
    q.item.key       = k;
    q.item.value     = v;
    q.drain          = 1'b0;
    op_queue.push_back(q);
    if (opc == OP_INSERT && gen_keys.size() < CAPACITY) gen_keys.push_back(k);
  endtask

  task automatic queue_drain();
    queued_op_t q;
    q.item  = '0;
    q.drain = 1'b1;
    op_queue.push_back(q);
  endtask

  // Key for a random operation: stored keys, near misses, corners or anything
  function automatic logic [15:0] pick_key(logic [1:0] opc);
    int          roll;
    logic [15:0] known;
    roll = $urandom_range(99);
    known = (gen_keys.size() > 0) ? gen_keys[$urandom_range(gen_keys.size() - 1)]
                                  : 16'(($urandom()));
    if (opc == OP_INSERT) begin
      if (roll < 25) return known;
      if (roll < 30) return 16'h0000;
      if (roll < 35) return 16'hFFFF;
      if (roll < 45) return known + 16'(($urandom_range(1) == 0) ? 1 : -1);
      return 16'($urandom());
    end
    if (roll < 70) return known;
    if (roll < 85) return known + 16'(($urandom_range(1) == 0) ? 1 : -1);
    return 16'($urandom());
  endfunction

  initial begin
    int         n;
    int         roll;
    logic [1:0] opc;

    // directed: empty table, corners, duplicates, hits and misses
    queue_op(OP_LIST,   16'h0000, 32'h0000_0000);
    queue_op(OP_LOOKUP, 16'h0000, 32'h0000_0000);
    queue_op(OP_UPDATE, 16'hFFFF, 32'hFFFF_FFFF);
    queue_op(OP_INSERT, 16'h8000, 32'hFFFF_FFFF);
    queue_op(OP_INSERT, 16'hFFFF, 32'h0000_0000);
    queue_op(OP_INSERT, 16'h0000, 32'hA5A5_A5A5);
    queue_op(OP_INSERT, 16'h0000, 32'h5A5A_5A5A);
    queue_op(OP_INSERT, 16'h8000, 32'h0000_0001);
    queue_op(OP_INSERT, 16'h7FFF, 32'h1234_5678);
    queue_op(OP_LOOKUP, 16'h0000, 32'h0000_0000);
    queue_op(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF);
    queue_op(OP_LOOKUP, 16'h8000, 32'h0000_0000);
    queue_op(OP_LOOKUP, 16'h1234, 32'h0000_0000);
    queue_op(OP_UPDATE, 16'h8000, 32'hDEAD_BEEF);
    queue_op(OP_UPDATE, 16'h4321, 32'h0BAD_F00D);
    queue_op(OP_UPDATE, 16'hFFFF, 32'hFFFF_FFFF);
    queue_op(OP_LIST,   16'h0000, 32'h0000_0000);
    queue_drain();

    // random: table fills over the first couple hundred, then stays full
    for (n = 0; n < 445; n++) begin
      roll = $urandom_range(99);
      if (roll < 14)      opc = OP_INSERT;
      else if (roll < 50) opc = OP_LOOKUP;
      else if (roll < 85) opc = OP_UPDATE;
      else                opc = OP_LIST;
      queue_op(opc, pick_key(opc), $urandom());
      if (n % 110 == 109) queue_drain();
    end

    // hold reset at the start, then release it
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // wait for everything to be sent and answered, then let the tail settle
    while (op_queue.size() > 0 || in_valid || expected_replies.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
